// ----- design/mtda_pkg.sv -----
`default_nettype none

package mtda_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [6:0] ASCII_ZERO  = 7'h30;
	localparam logic [6:0] ASCII_POINT = 7'h2E;

	localparam logic [1:0] W_TENTHOUSANDS = 2'd0;
	localparam logic [1:0] W_THOUSANDS    = 2'd1;
	localparam logic [1:0] W_HUNDREDS     = 2'd2;
	localparam logic [1:0] W_TENS         = 2'd3;

	typedef struct packed {
		logic [15:0] millis;
		logic        lead;
	} item_t;

	function automatic logic [16:0] mult_of(input logic [1:0] widx, input logic [3:0] k);
		logic [16:0] kk;
		logic [16:0] r;
		kk = {13'd0, k};
		case (widx)
			W_TENTHOUSANDS: r = kk * 17'd10000;
			W_THOUSANDS:    r = kk * 17'd1000;
			W_HUNDREDS:     r = kk * 17'd100;
			default:        r = kk * 17'd10;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/mtda_front.sv -----
`default_nettype none

module mtda_front import mtda_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] millis,
	output logic             q_valid,
	output item_t            q_item,
	input  wire logic        q_pop
);

	item_t      mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	item_t      new_item;

	assign in_ready = (count_q != 2'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = mem_q[rd_ptr_q];

	// The leading digit is sent only for counts of ten thousand and above.
	assign new_item.millis = millis;
	assign new_item.lead   = (millis >= 16'd10000);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

`default_nettype wire

// ----- design/mtda_back.sv -----
`default_nettype none

module mtda_back import mtda_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  wire item_t      q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [6:0]      character,
	output logic            final_char
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIGIT = 2'd1;
	localparam logic [1:0] ST_POINT = 2'd2;
	localparam logic [1:0] ST_ONES  = 2'd3;

	logic [1:0]  state_q, state_d;
	logic [1:0]  widx_q, widx_d;
	logic [15:0] rem_q, rem_d;
	logic        lead_q, lead_d;
	logic        out_valid_q;
	logic [6:0]  char_q;
	logic        final_q;

	logic        advance;
	logic        emit;
	logic [6:0]  emit_char;
	logic        emit_final;
	logic [3:0]  digit;
	logic [16:0] sub;

	assign advance    = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign character  = char_q;
	assign final_char = final_q;

	always_comb begin
		digit = 4'd0;
		sub   = 17'd0;
		for (int k = 1; k <= 9; k++) begin
			if ({1'b0, rem_q} >= mult_of(widx_q, 4'(k))) begin
				digit = 4'(k);
				sub   = mult_of(widx_q, 4'(k));
			end
		end
	end

	always_comb begin
		q_pop      = 1'b0;
		emit       = 1'b0;
		emit_char  = ASCII_ZERO;
		emit_final = 1'b0;
		state_d    = state_q;
		widx_d     = widx_q;
		rem_d      = rem_q;
		lead_d     = lead_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					rem_d   = q_item.millis;
					lead_d  = q_item.lead;
					widx_d  = W_TENTHOUSANDS;
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (widx_q == W_TENTHOUSANDS && !lead_q) begin
					widx_d = W_THOUSANDS;
				end else if (advance) begin
					emit      = 1'b1;
					emit_char = ASCII_ZERO + {3'd0, digit};
					rem_d     = rem_q - sub[15:0];
					widx_d    = widx_q + 2'd1;
					if (widx_q == W_THOUSANDS) begin
						state_d = ST_POINT;
					end else if (widx_q == W_TENS) begin
						state_d = ST_ONES;
					end
				end
			end
			ST_POINT: begin
				if (advance) begin
					emit      = 1'b1;
					emit_char = ASCII_POINT;
					state_d   = ST_DIGIT;
				end
			end
			ST_ONES: begin
				if (advance) begin
					emit       = 1'b1;
					emit_char  = ASCII_ZERO + {3'd0, rem_q[3:0]};
					emit_final = 1'b1;
					if (q_valid) begin
						q_pop   = 1'b1;
						rem_d   = q_item.millis;
						lead_d  = q_item.lead;
						widx_d  = W_TENTHOUSANDS;
						state_d = ST_DIGIT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rem_q  <= rem_d;
		lead_q <= lead_d;
		if (emit) begin
			char_q  <= emit_char;
			final_q <= emit_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			widx_q      <= W_TENTHOUSANDS;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			widx_q  <= widx_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/millis_to_decimal_ascii_top.sv -----
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_ready    millis[15:0]
// output    out_valid / out_ready  character[6:0], final_char
//
// In the back-end sequencer each count passes through one step per decimal digit
// or point and yields five or six characters; the step for the leading digit is
// spent even when that digit is not sent. A count that reaches an idle sequencer
// is first loaded from the queue in a step of its own.
// A two-entry queue lets the input side take new counts while output is stalled.
// Reset clears the queue, the sequencer state and the output valid flag.

module millis_to_decimal_ascii_top import mtda_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] millis,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [6:0]       character,
	output logic             final_char
);

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	mtda_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.millis   (millis),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	mtda_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.character  (character),
		.final_char (final_char)
	);

endmodule

`default_nettype wire

// ----- sim/tb_millis_to_decimal_ascii_top.sv -----
`default_nettype none

module tb_millis_to_decimal_ascii_top import mtda_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 3000;

	typedef struct {
		logic [6:0] code;
		logic       last;
	} ascii_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] millis = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [6:0]  character;
	logic        final_char;

	ascii_char_t pending_chars[$];
	int          error_count = 0;
	int          idle_cycles = 0;
	int          ready_hold = 0;
	bit          no_idle = 1'b0;

	millis_to_decimal_ascii_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.millis     (millis),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.character  (character),
		.final_char (final_char)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic void expect_char(input logic [6:0] code, input logic last);
		ascii_char_t c;
		c.code = code;
		c.last = last;
		pending_chars.push_back(c);
	endfunction

	// Expected text is seconds with three decimals, leading ten-thousands digit suppressed when zero.
	function automatic void predict_text(input logic [15:0] ms);
		int unsigned rest;
		int unsigned digit;
		int unsigned weights[4] = '{10000, 1000, 100, 10};
		rest = ms;
		for (int i = 0; i < 4; i++) begin
			digit = 0;
			while (rest >= weights[i]) begin
				rest -= weights[i];
				digit++;
			end
			if (i != 0 || digit != 0) begin
				expect_char(ASCII_ZERO + 7'(digit), 1'b0);
			end
			if (i == 1) begin
				expect_char(ASCII_POINT, 1'b0);
			end
		end
		expect_char(ASCII_ZERO + 7'(rest), 1'b1);
	endfunction

	function automatic logic [15:0] rand_count();
		int unsigned r;
		int unsigned v;
		r = $urandom_range(0, 9);
		case (r)
			4, 5: begin
				v = $urandom_range(0, 9999);
			end
			6: begin
				v = $urandom_range(0, 65) * 1000 + $urandom_range(0, 1);
			end
			7: begin
				v = $urandom_range(0, 5) * 10000;
				v += ($urandom_range(0, 1) ? $urandom_range(0, 9) : 0) * 1000;
				v += ($urandom_range(0, 1) ? $urandom_range(0, 9) : 0) * 100;
				v += ($urandom_range(0, 1) ? $urandom_range(0, 9) : 0) * 10;
				v += ($urandom_range(0, 1) ? $urandom_range(0, 9) : 0);
			end
			default: begin
				v = $urandom_range(0, 65535);
			end
		endcase
		return 16'(v);
	endfunction

	task automatic send_count(input logic [15:0] ms);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			millis <= 16'($urandom);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		millis <= ms;
		do @(posedge clk); while (!in_ready);
		predict_text(ms);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_counts();
		logic [15:0] counts[$] = '{
			16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
			16'd1001, 16'd9999, 16'd10000, 16'd10001, 16'd19999, 16'd20000,
			16'd30303, 16'd40004, 16'd50505, 16'd59999, 16'd60000, 16'd65534,
			16'd65535, 16'h5555, 16'hAAAA, 16'h8000, 16'h00FF
		};
		foreach (counts[i]) send_count(counts[i]);
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		repeat (10) send_count(rand_count());
		no_idle = 1'b0;
	endtask

	task automatic test_drain_pause();
		repeat (4) send_count(rand_count());
		wait_drained();
		repeat (4) send_count(rand_count());
	endtask

	task automatic test_random_counts();
		repeat (67) send_count(rand_count());
	endtask

	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			out_ready <= no_idle || ($urandom_range(0, 3) != 0);
			ready_hold <= pick_gap();
		end
	end

	always @(posedge clk) begin
		ascii_char_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected character, expected none, actual %h last %b",
					$time, character, final_char);
				error_count++;
			end else begin
				want = pending_chars.pop_front();
				if (character !== want.code) begin
					$display("%0t: character mismatch, expected %h, actual %h",
						$time, want.code, character);
					error_count++;
				end
				if (final_char !== want.last) begin
					$display("%0t: final_char mismatch, expected %b, actual %b",
						$time, want.last, final_char);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL millis_to_decimal_ascii_top");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_counts();
		test_back_to_back();
		test_drain_pause();
		test_random_counts();
		wait_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_chars.size() == 0) begin
			$display("PASS millis_to_decimal_ascii_top");
		end else begin
			$display("FAIL millis_to_decimal_ascii_top");
		end
		$finish;
	end

endmodule

`default_nettype wire
